/* rtl/hdmcd_pkg.sv */
// ----------------------------------------------------------------------------
// hdmcd_pkg
// Shared constants, types and hash/modulo helpers of the cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

package hdmcd_pkg;

	localparam int SLOTS     = 32;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int CFG_W     = 6;
	localparam int BLK_W     = 64;
	localparam int ACT_W     = 2;
	localparam int ADDR_W    = 3;
	localparam int MOD_STEPS = 4;
	localparam int MOD_BITS  = 32 / MOD_STEPS;
	localparam int CNT_W     = $clog2(MOD_STEPS);
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

	// register index held in paddr[2]
	localparam logic REG_SLOTS_IN_USE = 1'b0;

	localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

	typedef enum logic [1:0] {
		KIND_HIT  = 2'd0,
		KIND_FILL = 2'd1,
		KIND_WB   = 2'd2,
		KIND_DONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_HASH,
		F_MOD,
		F_PUSH
	} f_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_LOOK,
		B_WB,
		B_FINAL,
		B_FL_RD,
		B_FL_CHK,
		B_DONE
	} b_state_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [BLK_W-1:0]  blk;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	typedef struct packed {
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
		logic [BLK_W-1:0]  addr;
		logic              last;
	} res_t;

	function automatic logic [BLK_W-1:0] mix_a(input logic [BLK_W-1:0] v);
		return (~v) + (v << 18);
	endfunction

	// xor-shift then multiply by 21 as shift-add
	function automatic logic [BLK_W-1:0] mix_b(input logic [BLK_W-1:0] v);
		logic [BLK_W-1:0] t;
		t = v ^ (v >> 31);
		return t + (t << 2) + (t << 4);
	endfunction

	function automatic logic [BLK_W-1:0] mix_cd(input logic [BLK_W-1:0] v);
		logic [BLK_W-1:0] t;
		t = v ^ (v >> 11);
		t = t + (t << 6);
		return t ^ (t >> 22);
	endfunction

	// restoring remainder, one bit per step, MSB first
	function automatic logic [SLOT_W-1:0] mod_step(
		input logic [SLOT_W-1:0]   rem,
		input logic [MOD_BITS-1:0] bits,
		input logic [CFG_W-1:0]    m
	);
		logic [SLOT_W:0]   r;
		logic [SLOT_W-1:0] acc;
		acc = rem;
		for (int i = MOD_BITS - 1; i >= 0; i--) begin
			r = {acc, bits[i]};
			if (r >= (SLOT_W+1)'(m)) begin
				r = r - (SLOT_W+1)'(m);
			end
			acc = r[SLOT_W-1:0];
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

/* rtl/hashed_direct_mapped_cache_directory.sv */
// ----------------------------------------------------------------------------
// hashed_direct_mapped_cache_directory
// Tag and dirty directory of a hashed direct-mapped write-back block cache.
//
// Input queue (push/full): one word = action and block_number. Action three
// is taken and dropped. Result queue (empty/pop): kind, slot, block_address,
// last; each read or write yields one or two results, a flush up to
// SLOTS+1, and the final result of an input carries last.
// Front: accept, hash, remainder (8 bits at a time) and hand-over; a
// flush goes from accept straight to hand-over. The front takes no new
// word until the last one is handed to the command queue. Back: lookup,
// an optional writeback result, then the final result; a flush walks the
// tag RAM, reading and then checking one slot after another.
// A two-word command queue and a two-word result queue decouple the sides;
// a stalled result queue halts the back, then the front, with full held high.
// Reset empties both queues, clears all valid and dirty marks (tags need no
// clearing) and sets slots_in_use to 32. The APB register at address 0 is
// slots_in_use; write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_direct_mapped_cache_directory (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [hdmcd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [hdmcd_pkg::ACT_W-1:0]  action,
	input  wire logic [hdmcd_pkg::BLK_W-1:0]  block_number,
	output logic                              empty,
	input  wire logic                         pop,
	output logic      [1:0]                   kind,
	output logic      [hdmcd_pkg::SLOT_W-1:0] slot,
	output logic      [hdmcd_pkg::BLK_W-1:0]  block_address,
	output logic                              last
);
	import hdmcd_pkg::*;

	logic [CFG_W-1:0] slots_in_use_q;
	logic             q_push, q_full, q_pop, q_empty;
	cmd_t             q_wdata, q_rdata;
	res_t             res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SLOTS_IN_USE) ? {{(32-CFG_W){1'b0}}, slots_in_use_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= CFG_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SLOTS_IN_USE) begin
			slots_in_use_q <= pwdata[CFG_W-1:0];
		end
	end

	hdmcd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.block_number (block_number),
		.slots_in_use (slots_in_use_q),
		.q_push       (q_push),
		.q_data       (q_wdata),
		.q_full       (q_full)
	);

	hdmcd_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	hdmcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (q_empty),
		.cmd       (q_rdata),
		.cmd_pop   (q_pop),
		.res       (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	assign kind          = res.kind;
	assign slot          = res.slot;
	assign block_address = res.addr;
	assign last          = res.last;

endmodule

`default_nettype wire

/* rtl/hdmcd_front.sv */
// ----------------------------------------------------------------------------
// hdmcd_front
// Takes words, hashes the block number and reduces it to a slot.
// ----------------------------------------------------------------------------
`default_nettype none

module hdmcd_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [hdmcd_pkg::ACT_W-1:0]  action,
	input  wire logic [hdmcd_pkg::BLK_W-1:0]  block_number,
	input  wire logic [hdmcd_pkg::CFG_W-1:0]  slots_in_use,
	output logic                              q_push,
	output hdmcd_pkg::cmd_t                   q_data,
	input  wire logic                         q_full
);
	import hdmcd_pkg::*;

	f_state_t          state_q, state_d;
	logic [CNT_W-1:0]  step_q;
	logic [ACT_W-1:0]  action_q;
	logic [BLK_W-1:0]  blk_q;
	logic [BLK_W-1:0]  v_q;
	logic [SLOT_W-1:0] rem_q;
	logic [CFG_W-1:0]  m;

	always_comb begin
		m = slots_in_use;
		if (slots_in_use == '0) begin
			m = CFG_W'(1);
		end else if (slots_in_use > CFG_W'(SLOTS)) begin
			m = CFG_W'(SLOTS);
		end
	end

	always_comb begin
		state_d = state_q;
		full    = 1'b1;
		q_push  = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				full = 1'b0;
				if (push) begin
					if (action == ACT_FLUSH) begin
						state_d = F_PUSH;
					end else if (action == ACT_READ || action == ACT_WRITE) begin
						state_d = F_HASH;
					end
				end
			end
			F_HASH: begin
				if (step_q == CNT_W'(1)) begin
					state_d = F_MOD;
				end
			end
			F_MOD: begin
				if (step_q == CNT_W'(MOD_STEPS - 1)) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					q_push  = 1'b1;
					state_d = F_IDLE;
				end
			end
		endcase
	end

	assign q_data = '{action: action_q, blk: blk_q, slot: rem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_HASH || state_q == F_MOD) begin
				if (state_d != state_q) begin
					step_q <= '0;
				end else begin
					step_q <= step_q + CNT_W'(1);
				end
			end else begin
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (push) begin
					action_q <= action;
					blk_q    <= block_number;
					v_q      <= mix_a(block_number);
					rem_q    <= '0;
				end
			end
			F_HASH: begin
				if (step_q == '0) begin
					v_q <= mix_b(v_q);
				end else begin
					v_q <= mix_cd(v_q);
				end
			end
			F_MOD: begin
				rem_q <= mod_step(rem_q, v_q[31 -: MOD_BITS], m);
				v_q   <= {v_q[BLK_W-1:32], v_q[31-MOD_BITS:0], {MOD_BITS{1'b0}}};
			end
			F_PUSH: ;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/hdmcd_cmd_queue.sv */
// ----------------------------------------------------------------------------
// hdmcd_cmd_queue
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module hdmcd_cmd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire hdmcd_pkg::cmd_t wdata,
	output logic                 full,
	input  wire logic            pop,
	output hdmcd_pkg::cmd_t      rdata,
	output logic                 empty
);
	import hdmcd_pkg::*;

	cmd_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign full    = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign rdata   = ent_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

/* rtl/hdmcd_back.sv */
// ----------------------------------------------------------------------------
// hdmcd_back
// Tag/dirty directory: lookups, evictions, fills, flush walk; result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hdmcd_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_empty,
	input  wire hdmcd_pkg::cmd_t cmd,
	output logic                 cmd_pop,
	output hdmcd_pkg::res_t      res,
	output logic                 res_empty,
	input  wire logic            res_pop
);
	import hdmcd_pkg::*;

	b_state_t          state_q, state_d;
	cmd_t              cmd_q;
	logic [SLOTS-1:0]  valid_q, dirty_q;
	kind_t             kind_q;
	logic              hit_q;
	logic [SLOT_W-1:0] cursor_q;

	// tag store
	logic [BLK_W-1:0]  tag_mem [SLOTS];
	logic [BLK_W-1:0]  tag_rd_q;
	logic              rd_en, wr_en;
	logic [SLOT_W-1:0] rd_addr;

	logic  look_hit, fl_wb, fl_adv, fin_go;
	kind_t look_kind;
	logic  emit, ofull, opush;
	res_t  emit_res;

	// result queue
	res_t              oent_q [QDEPTH];
	logic [QPTR_W-1:0] owp_q, orp_q;
	logic [QPTR_W:0]   ocnt_q;
	logic              opop;

	assign look_hit  = valid_q[cmd_q.slot] && (tag_rd_q == cmd_q.blk);
	assign look_kind = (cmd_q.action == ACT_READ && !look_hit) ? KIND_FILL : KIND_HIT;
	assign fl_wb     = valid_q[cursor_q] && dirty_q[cursor_q];
	assign fl_adv    = (state_q == B_FL_CHK) && (!fl_wb || !ofull);
	assign fin_go    = (state_q == B_FINAL) && !ofull;

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = cmd.slot;
		wr_en    = 1'b0;
		emit     = 1'b0;
		emit_res = '{kind: KIND_HIT, slot: cmd_q.slot, addr: cmd_q.blk, last: 1'b1};
		unique case (state_q)
			B_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					rd_en   = 1'b1;
					state_d = (cmd.action == ACT_FLUSH) ? B_FL_RD : B_LOOK;
				end
			end
			B_LOOK: begin
				if (!look_hit && valid_q[cmd_q.slot] && dirty_q[cmd_q.slot]) begin
					state_d = B_WB;
				end else begin
					state_d = B_FINAL;
				end
			end
			B_WB: begin
				emit     = 1'b1;
				emit_res = '{kind: KIND_WB, slot: cmd_q.slot, addr: tag_rd_q, last: 1'b0};
				if (!ofull) begin
					state_d = B_FINAL;
				end
			end
			B_FINAL: begin
				emit     = 1'b1;
				emit_res = '{kind: kind_q, slot: cmd_q.slot, addr: cmd_q.blk, last: 1'b1};
				if (!ofull) begin
					wr_en   = 1'b1;
					state_d = B_IDLE;
				end
			end
			B_FL_RD: begin
				rd_en   = 1'b1;
				rd_addr = cursor_q;
				state_d = B_FL_CHK;
			end
			B_FL_CHK: begin
				emit     = fl_wb;
				emit_res = '{kind: KIND_WB, slot: cursor_q, addr: tag_rd_q, last: 1'b0};
				if (fl_adv) begin
					state_d = (cursor_q == SLOT_W'(SLOTS - 1)) ? B_DONE : B_FL_RD;
				end
			end
			B_DONE: begin
				emit     = 1'b1;
				emit_res = '{kind: KIND_DONE, slot: '0, addr: '0, last: 1'b1};
				if (!ofull) begin
					state_d = B_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			valid_q  <= '0;
			dirty_q  <= '0;
			cursor_q <= '0;
		end else begin
			state_q <= state_d;
			if (fin_go && !(cmd_q.action == ACT_READ && hit_q)) begin
				valid_q[cmd_q.slot] <= 1'b1;
				dirty_q[cmd_q.slot] <= (cmd_q.action == ACT_WRITE);
			end
			if (fl_adv) begin
				valid_q[cursor_q] <= 1'b0;
				dirty_q[cursor_q] <= 1'b0;
				cursor_q <= (cursor_q == SLOT_W'(SLOTS - 1)) ? '0 : cursor_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == B_LOOK) begin
			kind_q <= look_kind;
			hit_q  <= look_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			tag_rd_q <= tag_mem[rd_addr];
		end
		if (wr_en) begin
			tag_mem[cmd_q.slot] <= cmd_q.blk;
		end
	end

	// result queue
	assign ofull     = (ocnt_q == (QPTR_W+1)'(QDEPTH));
	assign res_empty = (ocnt_q == '0);
	assign res       = oent_q[orp_q];
	assign opush     = emit && !ofull;
	assign opop      = res_pop && !res_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (opush) begin
				owp_q <= owp_q + QPTR_W'(1);
			end
			if (opop) begin
				orp_q <= orp_q + QPTR_W'(1);
			end
			if (opush && !opop) begin
				ocnt_q <= ocnt_q + (QPTR_W+1)'(1);
			end else if (opop && !opush) begin
				ocnt_q <= ocnt_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (opush) begin
			oent_q[owp_q] <= emit_res;
		end
	end

endmodule

`default_nettype wire

/* rtl/hdmcd_checker.sv */
// ----------------------------------------------------------------------------
// hdmcd_checker
// Port-level checks on the result queue of the cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

module hdmcd_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         empty,
	input wire logic                         pop,
	input wire logic [1:0]                   kind,
	input wire logic [hdmcd_pkg::SLOT_W-1:0] slot,
	input wire logic [hdmcd_pkg::BLK_W-1:0]  block_address,
	input wire logic                         last
);
	import hdmcd_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable({kind, slot, block_address, last})))
		else $error("waiting result word changed or vanished");

	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_DONE) |-> (slot == '0 && block_address == '0 && last))
		else $error("flush done word malformed");

	a_wb_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_WB) |-> !last)
		else $error("writeback word marked last");

	a_fill_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_FILL) |-> last)
		else $error("fill word not marked last");

endmodule

bind hashed_direct_mapped_cache_directory hdmcd_checker u_hdmcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.kind          (kind),
	.slot          (slot),
	.block_address (block_address),
	.last          (last)
);

`default_nettype wire
